>>> src/char_stream_tokenizer_macros.svh
// Assertion helpers shared by the tokenizer modules.
`ifndef CHAR_STREAM_TOKENIZER_MACROS_SVH
`define CHAR_STREAM_TOKENIZER_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define CST_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

// A condition that, once seen, must be followed by another in the next cycle.
`define CST_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");

`endif

>>> src/cst_pkg.sv
// ----------------------------------------------------------------------------
// Character stream tokenizer package
// Token kinds, character classes, keyword table and shared record types.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int KW_MAX      = 5;
    localparam int KW_COUNT    = 6;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [4:0] K_NEWLINE = 5'd0;
    localparam logic [4:0] K_IDENT   = 5'd1;
    localparam logic [4:0] K_INT     = 5'd2;
    localparam logic [4:0] K_FLOAT   = 5'd3;
    localparam logic [4:0] K_KW_BASE = 5'd4;
    localparam logic [4:0] K_ASSIGN  = 5'd10;
    localparam logic [4:0] K_ARROW   = 5'd11;
    localparam logic [4:0] K_DOTDOT  = 5'd12;
    localparam logic [4:0] K_COLON   = 5'd25;
    localparam logic [4:0] K_UNKNOWN = 5'd27;
    localparam logic [4:0] K_END     = 5'd28;

    localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;
    localparam logic [15:0] LEN_MAX   = 16'hFFFF;

    typedef enum logic [6:0] {
        M_IDLE  = 7'b0000001,
        M_WORD  = 7'b0000010,
        M_INT   = 7'b0000100,
        M_FLOAT = 7'b0001000,
        M_COLON = 7'b0010000,
        M_MINUS = 7'b0100000,
        M_DOT   = 7'b1000000
    } t_mode;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [31:0] offset;
        logic [15:0] length;
        logic [30:0] value;
    } t_token;

    // An accepted character that yields tokens yields one or two of them.
    typedef struct packed {
        logic   has_two;
        t_token tok1;
        t_token tok0;
    } t_grp;

    typedef logic [KW_MAX-1:0][7:0] t_kw_word;

    localparam t_kw_word KW_TEXT [KW_COUNT] = '{
        {8'h00, "n", "a", "p", "s"},
        {"e", "g", "n", "a", "r"},
        {8'h00, 8'h00, "c", "e", "v"},
        {8'h00, 8'h00, "l", "i", "n"},
        {8'h00, "l", "l", "u", "n"},
        {8'h00, 8'h00, "t", "e", "l"}
    };
    localparam logic [15:0] KW_LEN [KW_COUNT] = '{16'd4, 16'd5, 16'd3, 16'd3, 16'd4, 16'd3};

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_";
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
    endfunction

    // Single-character punctuation; an unmatched byte is an unknown token.
    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        k = K_UNKNOWN;
        case (c)
            "!": k = 5'd13;
            "#": k = 5'd14;
            "=": k = 5'd15;
            "(": k = 5'd16;
            ")": k = 5'd17;
            "<": k = 5'd18;
            ">": k = 5'd19;
            "[": k = 5'd20;
            "]": k = 5'd21;
            "{": k = 5'd22;
            "}": k = 5'd23;
            ",": k = 5'd24;
            ":": k = K_COLON;
            ";": k = 5'd26;
            default: k = K_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] word_kind(input t_kw_word p, input logic [15:0] len);
        logic [4:0] k;
        logic       eq;
        k = K_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            eq = (len == KW_LEN[i]);
            for (int j = 0; j < KW_MAX; j++) begin
                if (j < KW_LEN[i] && p[j] != KW_TEXT[i][j]) begin
                    eq = 1'b0;
                end
            end
            if (eq) begin
                k = K_KW_BASE + 5'(i);
            end
        end
        return k;
    endfunction

endpackage

>>> src/char_stream_tokenizer.sv
// A token reaches the outputs through the group queue and then the back end's hold
// register, once the item that completes it has been accepted.
// Throughput: one item per cycle while the queue is not full; an item that completes
// two tokens occupies the output for both, and the four-group queue absorbs bursts.
// Tokens leave one per cycle while pop is high, from the single output register.
// Reset is synchronous and active low; it returns the lexer to idle at line 1,
// column 1, offset 0, and empties the queue.
// ----------------------------------------------------------------------------
// Character stream tokenizer
// Lexes a byte stream into tokens with position, length and integer value.
// ----------------------------------------------------------------------------
module char_stream_tokenizer #(
    parameter int POS_BITS      = 16,
    parameter int OFFSET_BITS   = 32,
    parameter int KEYWORD_CHARS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_code,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  o_token_kind,
    output logic [15:0] o_start_line,
    output logic [15:0] o_start_column,
    output logic [31:0] o_start_offset,
    output logic [15:0] o_token_length,
    output logic [30:0] o_int_value,
    output logic        o_run_end
);
    import cst_pkg::*;

    logic   accept, grp_valid, q_full, q_nonempty, q_pop;
    t_grp   grp, q_grp;
    t_token tok;

    assign full   = q_full;
    assign accept = push && !q_full;

    cst_front #(
        .POS_BITS      (POS_BITS),
        .OFFSET_BITS   (OFFSET_BITS),
        .KEYWORD_CHARS (KEYWORD_CHARS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_code (i_char_code),
        .o_grp_valid (grp_valid),
        .o_grp       (grp)
    );

    cst_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (grp_valid),
        .i_grp      (grp),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_grp      (q_grp)
    );

    cst_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_nonempty (q_nonempty),
        .i_q_grp      (q_grp),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_tok        (tok),
        .o_run_end    (o_run_end)
    );

    assign o_token_kind   = tok.kind;
    assign o_start_line   = tok.line;
    assign o_start_column = tok.column;
    assign o_start_offset = tok.offset;
    assign o_token_length = tok.length;
    assign o_int_value    = tok.value;

endmodule

>>> src/cst_front.sv
// ----------------------------------------------------------------------------
// Tokenizer front end
// Holds the lexer state, classifies each item and forms its token group.
// ----------------------------------------------------------------------------
module cst_front #(
    parameter int POS_BITS      = 16,
    parameter int OFFSET_BITS   = 32,
    parameter int KEYWORD_CHARS = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_char_code,
    output logic          o_grp_valid,
    output cst_pkg::t_grp o_grp
);
    import cst_pkg::*;

    t_mode                              r_mode, n_mode;
    logic [POS_BITS-1:0]                r_line, n_line, r_col, n_col;
    logic [OFFSET_BITS-1:0]             r_off, n_off;
    logic [15:0]                        r_tok_line, n_tok_line, r_tok_col, n_tok_col;
    logic [31:0]                        r_tok_off, n_tok_off;
    logic [15:0]                        r_tok_len, n_tok_len;
    logic [30:0]                        r_acc, n_acc;
    logic [KEYWORD_CHARS-1:0][7:0]      r_prefix, n_prefix;
    logic                               r_long, n_long;

    logic        adv, do_idle, pend_v, new_v;
    t_token      pend, tnew;
    logic [34:0] acc_x10;
    logic [7:0]  c;
    logic [15:0] len_inc;

    assign c       = i_char_code;
    assign len_inc = (r_tok_len == LEN_MAX) ? r_tok_len : r_tok_len + 16'd1;
    assign acc_x10 = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                   + {31'd0, c[3:0] - 4'd0};

    always_comb begin
        n_mode     = r_mode;
        n_line     = r_line;
        n_col      = r_col;
        n_off      = r_off;
        n_tok_line = r_tok_line;
        n_tok_col  = r_tok_col;
        n_tok_off  = r_tok_off;
        n_tok_len  = r_tok_len;
        n_acc      = r_acc;
        n_prefix   = r_prefix;
        n_long     = r_long;
        adv        = 1'b0;
        do_idle    = 1'b0;
        pend_v     = 1'b0;
        new_v      = 1'b0;
        pend       = '{kind: K_IDENT, line: r_tok_line, column: r_tok_col,
                       offset: r_tok_off, length: r_tok_len, value: '0};
        tnew       = '{kind: K_UNKNOWN, line: 16'(r_line), column: 16'(r_col),
                       offset: 32'(r_off), length: 16'd1, value: '0};

        unique case (r_mode)
            M_WORD: begin
                if (is_word(c)) begin
                    for (int i = 0; i < KEYWORD_CHARS; i++) begin
                        if (r_tok_len == 16'(i)) begin
                            n_prefix[i] = c;
                        end
                    end
                    if (r_tok_len >= 16'(KEYWORD_CHARS)) begin
                        n_long = 1'b1;
                    end
                    n_tok_len = len_inc;
                    adv       = 1'b1;
                end else begin
                    pend_v    = 1'b1;
                    pend.kind = r_long ? K_IDENT : word_kind(r_prefix[KW_MAX-1:0], r_tok_len);
                    do_idle   = 1'b1;
                end
            end
            M_INT: begin
                if (is_digit(c)) begin
                    n_acc     = (acc_x10 > {4'd0, VALUE_MAX}) ? VALUE_MAX : acc_x10[30:0];
                    n_tok_len = len_inc;
                    adv       = 1'b1;
                end else if (c == ".") begin
                    n_mode    = M_FLOAT;
                    n_tok_len = len_inc;
                    adv       = 1'b1;
                end else begin
                    pend_v     = 1'b1;
                    pend.kind  = K_INT;
                    pend.value = r_acc;
                    do_idle    = 1'b1;
                end
            end
            M_FLOAT: begin
                if (is_digit(c)) begin
                    n_tok_len = len_inc;
                    adv       = 1'b1;
                end else begin
                    pend_v     = 1'b1;
                    pend.kind  = K_FLOAT;
                    pend.value = r_acc;
                    do_idle    = 1'b1;
                end
            end
            M_COLON, M_MINUS, M_DOT: begin
                pend_v = 1'b1;
                if ((r_mode == M_COLON && c == "=") || (r_mode == M_MINUS && c == ">")
                        || (r_mode == M_DOT && c == ".")) begin
                    pend.length = 16'd2;
                    pend.kind   = (r_mode == M_COLON) ? K_ASSIGN
                                : (r_mode == M_MINUS) ? K_ARROW : K_DOTDOT;
                    n_mode      = M_IDLE;
                    adv         = 1'b1;
                end else begin
                    pend.kind = (r_mode == M_COLON) ? K_COLON : K_UNKNOWN;
                    do_idle   = 1'b1;
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase

        if (do_idle) begin
            n_mode = M_IDLE;
            if (c == 8'h00) begin
                new_v       = 1'b1;
                tnew.kind   = K_END;
                tnew.length = 16'd0;
            end else if (c == 8'h0A) begin
                new_v     = 1'b1;
                tnew.kind = K_NEWLINE;
                adv       = 1'b1;
            end else if (is_blank(c)) begin
                adv = 1'b1;
            end else if (is_alpha(c) || c == "_" || is_digit(c)
                    || c == ":" || c == "-" || c == ".") begin
                // Start of a token whose end is seen only on a later item.
                n_tok_line = 16'(r_line);
                n_tok_col  = 16'(r_col);
                n_tok_off  = 32'(r_off);
                n_tok_len  = 16'd1;
                adv        = 1'b1;
                if (is_digit(c)) begin
                    n_mode = M_INT;
                    n_acc  = {27'd0, c[3:0]};
                end else if (c == ":") begin
                    n_mode = M_COLON;
                end else if (c == "-") begin
                    n_mode = M_MINUS;
                end else if (c == ".") begin
                    n_mode = M_DOT;
                end else begin
                    n_mode      = M_WORD;
                    n_prefix    = '0;
                    n_prefix[0] = c;
                    n_long      = 1'b0;
                end
            end else begin
                new_v     = 1'b1;
                tnew.kind = punct_kind(c);
                adv       = 1'b1;
            end
        end

        if (adv) begin
            if (c == 8'h0A) begin
                if (r_line != '1) begin
                    n_line = r_line + 1'b1;
                end
                n_col = POS_BITS'(1);
            end else if (r_col != '1) begin
                n_col = r_col + 1'b1;
            end
            n_off = r_off + 1'b1;
        end
    end

    always_comb begin
        o_grp.has_two = pend_v && new_v;
        o_grp.tok0    = pend_v ? pend : tnew;
        o_grp.tok1    = tnew;
        o_grp_valid   = i_accept && (pend_v || new_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= M_IDLE;
            r_line     <= POS_BITS'(1);
            r_col      <= POS_BITS'(1);
            r_off      <= '0;
            r_tok_line <= 16'd1;
            r_tok_col  <= 16'd1;
            r_tok_off  <= '0;
            r_tok_len  <= '0;
            r_acc      <= '0;
            r_prefix   <= '0;
            r_long     <= 1'b0;
        end else if (i_accept) begin
            r_mode     <= n_mode;
            r_line     <= n_line;
            r_col      <= n_col;
            r_off      <= n_off;
            r_tok_line <= n_tok_line;
            r_tok_col  <= n_tok_col;
            r_tok_off  <= n_tok_off;
            r_tok_len  <= n_tok_len;
            r_acc      <= n_acc;
            r_prefix   <= n_prefix;
            r_long     <= n_long;
        end
    end

endmodule

>>> src/cst_queue.sv
// ----------------------------------------------------------------------------
// Tokenizer group queue
// Short queue of token groups between the front and back ends.
// ----------------------------------------------------------------------------
`include "char_stream_tokenizer_macros.svh"

module cst_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cst_pkg::t_grp i_grp,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_nonempty,
    output cst_pkg::t_grp o_grp
);
    import cst_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_grp             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_count;

    assign o_full     = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_grp      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (PTR_W+1)'(i_push) - (PTR_W+1)'(i_pop);
        end
    end

    `CST_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= (PTR_W+1)'(QUEUE_DEPTH))
    `CST_ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full && !i_pop))
    `CST_ASSERT_ALWAYS(a_no_underflow, i_clk, i_rst_n, !(i_pop && !o_nonempty))
    `CST_ASSERT_NEXT(a_fill, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

>>> src/cst_back.sv
// ----------------------------------------------------------------------------
// Tokenizer back end
// Takes token groups from the queue and presents their tokens one by one.
// ----------------------------------------------------------------------------
module cst_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_nonempty,
    input  cst_pkg::t_grp  i_q_grp,
    output logic           o_q_pop,
    input  logic           i_pop,
    output logic           o_empty,
    output cst_pkg::t_token o_tok,
    output logic           o_run_end
);
    import cst_pkg::*;

    t_grp r_hold;
    logic r_valid, r_second;
    logic take, last, load;

    assign take      = i_pop && r_valid;
    assign last      = r_second || !r_hold.has_two;
    assign load      = (!r_valid || (take && last)) && i_q_nonempty;
    assign o_q_pop   = load;
    assign o_empty   = !r_valid;
    assign o_tok     = r_second ? r_hold.tok1 : r_hold.tok0;
    assign o_run_end = last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_hold <= i_q_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (!r_valid || (take && last)) begin
            r_valid  <= i_q_nonempty;
            r_second <= 1'b0;
        end else if (take) begin
            r_second <= 1'b1;
        end
    end

endmodule
